// ----- src/rvx_pkg.sv -----
// Package with the operation codes, field widths and pipeline types of the execute core.
`timescale 1ns / 1ps
package rvx_pkg;
   localparam int XLEN = 32;
   localparam int OPW = 6;
   localparam int RIW = 5;

   localparam logic [OPW-1:0] OP_ADD = 6'd0;
   localparam logic [OPW-1:0] OP_SUB = 6'd1;
   localparam logic [OPW-1:0] OP_SLT = 6'd2;
   localparam logic [OPW-1:0] OP_SLTU = 6'd3;
   localparam logic [OPW-1:0] OP_AND = 6'd4;
   localparam logic [OPW-1:0] OP_OR = 6'd5;
   localparam logic [OPW-1:0] OP_XOR = 6'd6;
   localparam logic [OPW-1:0] OP_SLL = 6'd7;
   localparam logic [OPW-1:0] OP_SRL = 6'd8;
   localparam logic [OPW-1:0] OP_SRA = 6'd9;
   localparam logic [OPW-1:0] OP_ADDI = 6'd10;
   localparam logic [OPW-1:0] OP_SLTI = 6'd11;
   localparam logic [OPW-1:0] OP_SLTIU = 6'd12;
   localparam logic [OPW-1:0] OP_ANDI = 6'd13;
   localparam logic [OPW-1:0] OP_ORI = 6'd14;
   localparam logic [OPW-1:0] OP_XORI = 6'd15;
   localparam logic [OPW-1:0] OP_SLLI = 6'd16;
   localparam logic [OPW-1:0] OP_SRLI = 6'd17;
   localparam logic [OPW-1:0] OP_SRAI = 6'd18;
   localparam logic [OPW-1:0] OP_BEQ = 6'd19;
   localparam logic [OPW-1:0] OP_BGE = 6'd20;
   localparam logic [OPW-1:0] OP_BGEU = 6'd21;
   localparam logic [OPW-1:0] OP_BLT = 6'd22;
   localparam logic [OPW-1:0] OP_BLTU = 6'd23;
   localparam logic [OPW-1:0] OP_BNE = 6'd24;
   localparam logic [OPW-1:0] OP_JAL = 6'd25;
   localparam logic [OPW-1:0] OP_JALR = 6'd26;
   localparam logic [OPW-1:0] OP_AUIPC = 6'd27;
   localparam logic [OPW-1:0] OP_LUI = 6'd28;
   localparam logic [OPW-1:0] OP_LB = 6'd29;
   localparam logic [OPW-1:0] OP_LBU = 6'd30;
   localparam logic [OPW-1:0] OP_LH = 6'd31;
   localparam logic [OPW-1:0] OP_LHU = 6'd32;
   localparam logic [OPW-1:0] OP_LW = 6'd33;
   localparam logic [OPW-1:0] OP_SB = 6'd34;
   localparam logic [OPW-1:0] OP_SH = 6'd35;
   localparam logic [OPW-1:0] OP_SW = 6'd36;
   localparam logic [OPW-1:0] OP_HCF = 6'd37;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic REQ_EXEC = 1'b0;
   localparam logic REQ_LOAD_RESP = 1'b1;

   localparam int UPPER_SHIFT = 12;
   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   typedef struct packed {
      logic req_type;
      logic [OPW-1:0] opcode;
      logic [RIW-1:0] first_reg;
      logic [RIW-1:0] second_reg;
      logic [RIW-1:0] third_reg;
      logic signed [XLEN-1:0] immediate;
      logic [XLEN-1:0] load_data;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0] next_pc;
      logic mem_request;
      logic mem_is_write;
      logic [XLEN-1:0] mem_address;
      logic [XLEN-1:0] mem_write_data;
      logic [1:0] mem_size;
      logic load_is_unsigned;
      logic halted;
      logic unimplemented_seen;
      logic [XLEN-1:0] retired_count;
   } rsp_type;

   // Register-file write request, also used for forwarding.
   typedef struct packed {
      logic en;
      logic [RIW-1:0] addr;
      logic [XLEN-1:0] data;
   } rf_wr_type;
endpackage

// ----- src/rvx_if.sv -----
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps
interface rvx_req_if;
   logic valid;
   logic ready;
   rvx_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rvx_rsp_if;
   logic valid;
   logic ready;
   rvx_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/rvx_regfile.sv -----
// Register file memory with two registered read ports and one write port.
`timescale 1ns / 1ps
module rvx_regfile #(
   parameter int REG_COUNT = 32
) (
   input logic clock,
   input logic reset,
   input logic rd_en,
   input logic [rvx_pkg::RIW-1:0] rd_addr_a,
   input logic [rvx_pkg::RIW-1:0] rd_addr_b,
   output logic [rvx_pkg::XLEN-1:0] rd_data_a,
   output logic [rvx_pkg::XLEN-1:0] rd_data_b,
   input rvx_pkg::rf_wr_type wr
);
   localparam int AW = $clog2(REG_COUNT);
   logic [rvx_pkg::XLEN-1:0] mem [REG_COUNT];
   // One bit per entry marks it as written since reset; unwritten entries read as zero.
   logic [REG_COUNT-1:0] written_ff;
   logic [rvx_pkg::XLEN-1:0] raw_a_ff, raw_b_ff;
   logic hit_a_ff, hit_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         raw_a_ff <= mem[rd_addr_a[AW-1:0]];
         raw_b_ff <= mem[rd_addr_b[AW-1:0]];
         hit_a_ff <= written_ff[rd_addr_a[AW-1:0]];
         hit_b_ff <= written_ff[rd_addr_b[AW-1:0]];
      end
   end

   assign rd_data_a = hit_a_ff ? raw_a_ff : '0;
   assign rd_data_b = hit_b_ff ? raw_b_ff : '0;
endmodule

// ----- src/rvx_alu.sv -----
// Combinational execute logic: ALU, branch decision and memory request for one instruction.
`timescale 1ns / 1ps
module rvx_alu (
   input logic [rvx_pkg::OPW-1:0] opcode,
   input logic [rvx_pkg::XLEN-1:0] a,
   input logic [rvx_pkg::XLEN-1:0] b,
   input logic [rvx_pkg::XLEN-1:0] f,
   input logic [rvx_pkg::XLEN-1:0] imm,
   input logic [rvx_pkg::XLEN-1:0] pc,
   output logic [rvx_pkg::XLEN-1:0] result,
   output logic wr_dest,
   output logic [rvx_pkg::XLEN-1:0] pc_next,
   output logic is_load,
   output logic is_store,
   output logic [rvx_pkg::XLEN-1:0] addr,
   output logic [1:0] size,
   output logic uns,
   output logic hcf,
   output logic unimpl
);
   logic [rvx_pkg::XLEN-1:0] pc4;
   logic [rvx_pkg::XLEN-1:0] opnd;
   logic [4:0] sh;
   logic lt_s;
   logic lt_u;
   logic blt_s;
   logic blt_u;
   logic take;

   always_comb begin
      pc4 = pc + rvx_pkg::PC_STEP;
      opnd = (opcode < rvx_pkg::OP_ADDI) ? b : imm;
      sh = opnd[4:0];
      lt_s = $signed(a) < $signed(opnd);
      lt_u = a < opnd;
      blt_s = $signed(f) < $signed(a);
      blt_u = f < a;
      addr = a + imm;
      result = '0;
      wr_dest = 1'b1;
      take = 1'b0;
      is_load = 1'b0;
      is_store = 1'b0;
      size = rvx_pkg::SIZE_BYTE;
      uns = 1'b0;
      hcf = 1'b0;
      unimpl = 1'b0;
      pc_next = pc4;
      case (opcode)
         rvx_pkg::OP_ADD, rvx_pkg::OP_ADDI: result = a + opnd;
         rvx_pkg::OP_SUB: result = a - opnd;
         rvx_pkg::OP_SLT, rvx_pkg::OP_SLTI: result = {31'd0, lt_s};
         rvx_pkg::OP_SLTU, rvx_pkg::OP_SLTIU: result = {31'd0, lt_u};
         rvx_pkg::OP_AND, rvx_pkg::OP_ANDI: result = a & opnd;
         rvx_pkg::OP_OR, rvx_pkg::OP_ORI: result = a | opnd;
         rvx_pkg::OP_XOR, rvx_pkg::OP_XORI: result = a ^ opnd;
         rvx_pkg::OP_SLL, rvx_pkg::OP_SLLI: result = a << sh;
         rvx_pkg::OP_SRL, rvx_pkg::OP_SRLI: result = a >> sh;
         rvx_pkg::OP_SRA, rvx_pkg::OP_SRAI: result = $unsigned($signed(a) >>> sh);
         rvx_pkg::OP_BEQ: begin wr_dest = 1'b0; take = (f == a); end
         rvx_pkg::OP_BNE: begin wr_dest = 1'b0; take = (f != a); end
         rvx_pkg::OP_BLT: begin wr_dest = 1'b0; take = blt_s; end
         rvx_pkg::OP_BGE: begin wr_dest = 1'b0; take = !blt_s; end
         rvx_pkg::OP_BLTU: begin wr_dest = 1'b0; take = blt_u; end
         rvx_pkg::OP_BGEU: begin wr_dest = 1'b0; take = !blt_u; end
         rvx_pkg::OP_JAL: begin result = pc4; take = 1'b1; end
         rvx_pkg::OP_JALR: begin
            result = pc4;
            pc_next = {addr[rvx_pkg::XLEN-1:1], 1'b0};
         end
         rvx_pkg::OP_AUIPC: result = pc + (imm << rvx_pkg::UPPER_SHIFT);
         rvx_pkg::OP_LUI: result = imm << rvx_pkg::UPPER_SHIFT;
         rvx_pkg::OP_LB, rvx_pkg::OP_LBU, rvx_pkg::OP_LH, rvx_pkg::OP_LHU,
         rvx_pkg::OP_LW: begin
            wr_dest = 1'b0;
            is_load = 1'b1;
            pc_next = pc;
            size = (opcode == rvx_pkg::OP_LW) ? rvx_pkg::SIZE_WORD :
                   ((opcode == rvx_pkg::OP_LH || opcode == rvx_pkg::OP_LHU) ?
                    rvx_pkg::SIZE_HALF : rvx_pkg::SIZE_BYTE);
            uns = (opcode == rvx_pkg::OP_LBU || opcode == rvx_pkg::OP_LHU);
         end
         rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW: begin
            wr_dest = 1'b0;
            is_store = 1'b1;
            size = (opcode == rvx_pkg::OP_SW) ? rvx_pkg::SIZE_WORD :
                   ((opcode == rvx_pkg::OP_SH) ? rvx_pkg::SIZE_HALF : rvx_pkg::SIZE_BYTE);
         end
         rvx_pkg::OP_HCF: begin wr_dest = 1'b0; hcf = 1'b1; end
         default: begin wr_dest = 1'b0; unimpl = 1'b1; end
      endcase
      if (take) begin
         pc_next = imm;
      end
   end
endmodule

// ----- src/rv32i_execute_core_unit.sv -----
// Top level of the RV32I execute core.
`timescale 1ns / 1ps
// An accepted item reads the register file at its accepting edge into stage 1 and executes
// there once the result register is free or being taken; its result item is then registered.
// With the result channel ready, one item is accepted every cycle. A waiting result holds
// the input until it is taken. The write of the item executed just before is forwarded into
// the operands. While a load waits for its response item, instruction items are accepted
// but ignored; every item gives exactly one result item.
module rv32i_execute_core_unit #(
   parameter int REG_COUNT = 32
) (
   input logic clock,
   input logic reset,
   rvx_req_if.sink req,
   rvx_rsp_if.source rsp
);
   localparam int XL = rvx_pkg::XLEN;
   localparam int RW = rvx_pkg::RIW;

   // Stage 1 holds an accepted item while the memory read completes.
   logic s1_valid_ff, s1_valid_in;
   rvx_pkg::req_type s1_ff;
   logic [RW-1:0] rd_c_ff;

   logic [XL-1:0] pc_ff, pc_in;
   logic [XL-1:0] cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   logic [RW-1:0] pdest_ff, pdest_in;
   logic halt_ff, halt_in;

   logic out_valid_ff;
   rvx_pkg::rsp_type out_ff, out_in;

   logic [XL-1:0] rf_a, rf_b;
   rvx_pkg::rf_wr_type wr, wr_ff;
   logic advance;
   logic [XL-1:0] a, b, f;
   logic [XL-1:0] result, pc_next, addr;
   logic wr_dest, is_load, is_store, uns, hcf, unimpl;
   logic [1:0] size;
   logic exec_ok;

   function automatic logic valid_idx(input logic [RW-1:0] i);
      return (i != '0) && (32'(i) < REG_COUNT);
   endfunction

   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // The first and third register reads share port b, selected by the opcode as the item is accepted.
   rvx_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
      .clock(clock),
      .reset(reset),
      .rd_en(advance),
      .rd_addr_a(req.data.second_reg),
      .rd_addr_b(req.data.opcode < rvx_pkg::OP_ADDI ? req.data.third_reg : req.data.first_reg),
      .rd_data_a(rf_a),
      .rd_data_b(rf_b),
      .wr(wr)
   );

   function automatic logic [XL-1:0] opnd(input logic [RW-1:0] i,
                                          input logic [XL-1:0] mem_v,
                                          input rvx_pkg::rf_wr_type w);
      logic [XL-1:0] v;
      v = mem_v;
      if (w.en && w.addr == i) v = w.data;
      if (!valid_idx(i)) v = '0;
      return v;
   endfunction

   // wr_ff is the write committed in the cycle the memory was read, which the read missed.
   always_comb begin
      a = opnd(s1_ff.second_reg, rf_a, wr_ff);
      b = opnd(rd_c_ff, rf_b, wr_ff);
      f = b;
      if (s1_ff.opcode < rvx_pkg::OP_ADDI) f = '0;
   end

   rvx_alu u_alu (
      .opcode(s1_ff.opcode), .a(a), .b(b), .f(f), .imm(s1_ff.immediate),
      .pc(pc_ff), .result(result), .wr_dest(wr_dest), .pc_next(pc_next),
      .is_load(is_load), .is_store(is_store), .addr(addr), .size(size),
      .uns(uns), .hcf(hcf), .unimpl(unimpl)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      pc_in = pc_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      pdest_in = pdest_ff;
      halt_in = halt_ff;
      wr = '0;
      exec_ok = 1'b0;
      out_in = out_ff;
      if (advance) begin
         s1_valid_in = req.valid;
      end
      if (advance && s1_valid_ff) begin
         out_in = '0;
         if (s1_ff.req_type == rvx_pkg::REQ_LOAD_RESP) begin
            if (pend_ff) begin
               wr.en = valid_idx(pdest_ff);
               wr.addr = pdest_ff;
               wr.data = s1_ff.load_data;
               pend_in = 1'b0;
               pc_in = pc_ff + rvx_pkg::PC_STEP;
            end
         end else if (!pend_ff && !halt_ff) begin
            exec_ok = 1'b1;
            cnt_in = cnt_ff + 32'd1;
            pc_in = pc_next;
            wr.en = wr_dest && valid_idx(s1_ff.first_reg);
            wr.addr = s1_ff.first_reg;
            wr.data = result;
            if (is_load) begin
               pend_in = 1'b1;
               pdest_in = s1_ff.first_reg;
            end
            if (hcf) halt_in = 1'b1;
         end
         out_in.next_pc = pc_in;
         out_in.mem_request = exec_ok && (is_load || is_store);
         out_in.mem_is_write = exec_ok && is_store;
         out_in.mem_address = (exec_ok && (is_load || is_store)) ? addr : '0;
         out_in.mem_write_data = (exec_ok && is_store) ? f : '0;
         out_in.mem_size = (exec_ok && (is_load || is_store)) ? size : rvx_pkg::SIZE_BYTE;
         out_in.load_is_unsigned = exec_ok && uns;
         out_in.halted = halt_in;
         out_in.unimplemented_seen = exec_ok && unimpl;
         out_in.retired_count = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff <= '0;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         pdest_ff <= '0;
         halt_ff <= 1'b0;
         wr_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) out_valid_ff <= s1_valid_ff;
         pc_ff <= pc_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         pdest_ff <= pdest_in;
         halt_ff <= halt_in;
         if (advance) wr_ff <= wr;
      end
      if (advance) begin
         s1_ff <= req.data;
         rd_c_ff <= (req.data.opcode < rvx_pkg::OP_ADDI) ? req.data.third_reg :
                    req.data.first_reg;
      end
      out_ff <= out_in;
   end

   // Entries not written since reset read as zero through the written-entry bits of the
   // register file.
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
endmodule

// ----- dv/tb_rv32i_execute_core_unit.sv -----
// Self-checking testbench for the RV32I execute core: directed and random instruction streams.
`timescale 1ns / 1ps
module tb_rv32i_execute_core_unit;
   localparam int XLEN = rvx_pkg::XLEN;
   localparam int OPW = rvx_pkg::OPW;
   localparam int RIW = rvx_pkg::RIW;
   localparam logic [OPW-1:0] OP_UNIMPL = rvx_pkg::OP_HCF + 6'd1;
   localparam logic [OPW-1:0] OP_LAST = 6'd63;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 740;

   logic clock;
   logic reset;

   rvx_req_if req_ch ();
   rvx_rsp_if rsp_ch ();

   rv32i_execute_core_unit #(.REG_COUNT(32)) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   rvx_pkg::req_type pending_items[$];
   rvx_pkg::rsp_type expected_results[$];

   logic [XLEN-1:0] gpr[32];
   logic [XLEN-1:0] pc_model;
   logic [XLEN-1:0] count_model;
   logic load_wait;
   logic [RIW-1:0] load_dest;
   logic halt_model;

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int idle_cycles;
   int accepted_count;
   int result_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [XLEN-1:0] read_gpr(logic [RIW-1:0] idx);
      return (idx == 0) ? '0 : gpr[idx];
   endfunction

   function automatic void write_gpr(logic [RIW-1:0] idx, logic [XLEN-1:0] value);
      if (idx != 0) gpr[idx] = value;
   endfunction

   function automatic rvx_pkg::rsp_type execute_item(rvx_pkg::req_type it);
      rvx_pkg::rsp_type r;
      logic [XLEN-1:0] a, b, f, imm, nxt;
      r = '0;
      imm = it.immediate;
      if (it.req_type == rvx_pkg::REQ_LOAD_RESP) begin
         if (load_wait) begin
            write_gpr(load_dest, it.load_data);
            load_wait = 1'b0;
            pc_model = pc_model + rvx_pkg::PC_STEP;
         end
      end else if (!load_wait && !halt_model) begin
         a = read_gpr(it.second_reg);
         b = read_gpr(it.third_reg);
         f = read_gpr(it.first_reg);
         nxt = pc_model + rvx_pkg::PC_STEP;
         count_model = count_model + 32'd1;
         case (it.opcode)
            rvx_pkg::OP_ADD: write_gpr(it.first_reg, a + b);
            rvx_pkg::OP_SUB: write_gpr(it.first_reg, a - b);
            rvx_pkg::OP_SLT: write_gpr(it.first_reg, {31'b0, $signed(a) < $signed(b)});
            rvx_pkg::OP_SLTU: write_gpr(it.first_reg, {31'b0, a < b});
            rvx_pkg::OP_AND: write_gpr(it.first_reg, a & b);
            rvx_pkg::OP_OR: write_gpr(it.first_reg, a | b);
            rvx_pkg::OP_XOR: write_gpr(it.first_reg, a ^ b);
            rvx_pkg::OP_SLL: write_gpr(it.first_reg, a << b[4:0]);
            rvx_pkg::OP_SRL: write_gpr(it.first_reg, a >> b[4:0]);
            rvx_pkg::OP_SRA: write_gpr(it.first_reg, $signed(a) >>> b[4:0]);
            rvx_pkg::OP_ADDI: write_gpr(it.first_reg, a + imm);
            rvx_pkg::OP_SLTI: write_gpr(it.first_reg, {31'b0, $signed(a) < $signed(imm)});
            rvx_pkg::OP_SLTIU: write_gpr(it.first_reg, {31'b0, a < imm});
            rvx_pkg::OP_ANDI: write_gpr(it.first_reg, a & imm);
            rvx_pkg::OP_ORI: write_gpr(it.first_reg, a | imm);
            rvx_pkg::OP_XORI: write_gpr(it.first_reg, a ^ imm);
            rvx_pkg::OP_SLLI: write_gpr(it.first_reg, a << imm[4:0]);
            rvx_pkg::OP_SRLI: write_gpr(it.first_reg, a >> imm[4:0]);
            rvx_pkg::OP_SRAI: write_gpr(it.first_reg, $signed(a) >>> imm[4:0]);
            rvx_pkg::OP_BEQ: if (f == a) nxt = imm;
            rvx_pkg::OP_BGE: if (!($signed(f) < $signed(a))) nxt = imm;
            rvx_pkg::OP_BGEU: if (f >= a) nxt = imm;
            rvx_pkg::OP_BLT: if ($signed(f) < $signed(a)) nxt = imm;
            rvx_pkg::OP_BLTU: if (f < a) nxt = imm;
            rvx_pkg::OP_BNE: if (f != a) nxt = imm;
            rvx_pkg::OP_JAL: begin
               write_gpr(it.first_reg, pc_model + rvx_pkg::PC_STEP);
               nxt = imm;
            end
            rvx_pkg::OP_JALR: begin
               nxt = (a + imm) & ~32'd1;
               write_gpr(it.first_reg, pc_model + rvx_pkg::PC_STEP);
            end
            rvx_pkg::OP_AUIPC:
               write_gpr(it.first_reg, pc_model + (imm << rvx_pkg::UPPER_SHIFT));
            rvx_pkg::OP_LUI: write_gpr(it.first_reg, imm << rvx_pkg::UPPER_SHIFT);
            rvx_pkg::OP_LB, rvx_pkg::OP_LBU, rvx_pkg::OP_LH, rvx_pkg::OP_LHU,
            rvx_pkg::OP_LW: begin
               r.mem_request = 1'b1;
               r.mem_address = a + imm;
               r.mem_size = (it.opcode == rvx_pkg::OP_LW) ? rvx_pkg::SIZE_WORD :
                  ((it.opcode == rvx_pkg::OP_LH || it.opcode == rvx_pkg::OP_LHU) ?
                   rvx_pkg::SIZE_HALF : rvx_pkg::SIZE_BYTE);
               r.load_is_unsigned = (it.opcode == rvx_pkg::OP_LBU ||
                                     it.opcode == rvx_pkg::OP_LHU);
               load_wait = 1'b1;
               load_dest = it.first_reg;
               nxt = pc_model;
            end
            rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW: begin
               r.mem_request = 1'b1;
               r.mem_is_write = 1'b1;
               r.mem_address = a + imm;
               r.mem_write_data = f;
               r.mem_size = (it.opcode == rvx_pkg::OP_SB) ? rvx_pkg::SIZE_BYTE :
                  ((it.opcode == rvx_pkg::OP_SH) ? rvx_pkg::SIZE_HALF : rvx_pkg::SIZE_WORD);
            end
            rvx_pkg::OP_HCF: halt_model = 1'b1;
            default: r.unimplemented_seen = 1'b1;
         endcase
         pc_model = nxt;
      end
      r.next_pc = pc_model;
      r.halted = halt_model;
      r.retired_count = count_model;
      return r;
   endfunction

   function automatic rvx_pkg::req_type make_exec(logic [OPW-1:0] op, logic [RIW-1:0] r1,
         logic [RIW-1:0] r2, logic [RIW-1:0] r3, logic [XLEN-1:0] imm);
      rvx_pkg::req_type it;
      it.req_type = rvx_pkg::REQ_EXEC;
      it.opcode = op;
      it.first_reg = r1;
      it.second_reg = r2;
      it.third_reg = r3;
      it.immediate = imm;
      it.load_data = $urandom;
      return it;
   endfunction

   function automatic rvx_pkg::req_type make_resp(logic [XLEN-1:0] value);
      rvx_pkg::req_type it;
      it = make_exec(rvx_pkg::OP_ADD, RIW'($urandom), RIW'($urandom), RIW'($urandom),
                     $urandom);
      it.req_type = rvx_pkg::REQ_LOAD_RESP;
      it.load_data = value;
      return it;
   endfunction

   function automatic logic [XLEN-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal ops; loads are usually followed by their response item.
   task automatic queue_random(int n);
      rvx_pkg::req_type it;
      logic [OPW-1:0] op;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4) begin
            op = OPW'($urandom_range(OP_UNIMPL, OP_LAST));
         end else begin
            op = OPW'($urandom_range(rvx_pkg::OP_ADD, rvx_pkg::OP_SW));
         end
         it = make_exec(op, RIW'($urandom), RIW'($urandom), RIW'($urandom), pick_value());
         if ($urandom_range(0, 99) < 3) it.req_type = rvx_pkg::REQ_LOAD_RESP;
         pending_items.push_back(it);
         if (op >= rvx_pkg::OP_LB && op <= rvx_pkg::OP_LW) begin
            if ($urandom_range(0, 99) < 10)
               pending_items.push_back(make_exec(rvx_pkg::OP_ADD, 5'd1, 5'd2, 5'd3, 32'd0));
            if ($urandom_range(0, 99) < 95) pending_items.push_back(make_resp(pick_value()));
         end
      end
   endtask

   task automatic queue_directed();
      pending_items.push_back(make_resp(32'h1234_5678));
      pending_items.push_back(make_exec(rvx_pkg::OP_ADDI, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF));
      pending_items.push_back(make_exec(rvx_pkg::OP_ADDI, 5'd2, 5'd0, 5'd0, 32'h8000_0000));
      pending_items.push_back(make_exec(rvx_pkg::OP_LUI, 5'd3, 5'd0, 5'd0, 32'h000F_FFFF));
      pending_items.push_back(make_exec(rvx_pkg::OP_ADDI, 5'd0, 5'd1, 5'd0, 32'd5));
      pending_items.push_back(make_exec(rvx_pkg::OP_SLTU, 5'd4, 5'd2, 5'd1, 32'd0));
      pending_items.push_back(make_exec(rvx_pkg::OP_SLT, 5'd5, 5'd2, 5'd1, 32'd0));
      pending_items.push_back(make_exec(rvx_pkg::OP_SRA, 5'd6, 5'd2, 5'd1, 32'd0));
      pending_items.push_back(make_exec(rvx_pkg::OP_SLLI, 5'd7, 5'd1, 5'd0, 32'hFFFF_FFE3));
      pending_items.push_back(make_exec(rvx_pkg::OP_SRAI, 5'd8, 5'd2, 5'd0, 32'h0000_0025));
      pending_items.push_back(make_exec(rvx_pkg::OP_AUIPC, 5'd9, 5'd0, 5'd0, 32'h0000_0001));
      pending_items.push_back(make_exec(rvx_pkg::OP_JALR, 5'd1, 5'd1, 5'd0, 32'd8));
      pending_items.push_back(make_exec(rvx_pkg::OP_JAL, 5'd10, 5'd0, 5'd0, 32'h0000_0100));
      pending_items.push_back(make_exec(rvx_pkg::OP_BEQ, 5'd0, 5'd0, 5'd0, 32'h0000_0200));
      pending_items.push_back(make_exec(rvx_pkg::OP_BLTU, 5'd2, 5'd1, 5'd0, 32'h0000_0300));
      pending_items.push_back(make_exec(rvx_pkg::OP_SW, 5'd3, 5'd2, 5'd0, 32'hFFFF_FFFC));
      pending_items.push_back(make_exec(rvx_pkg::OP_LW, 5'd0, 5'd3, 5'd0, 32'd4));
      pending_items.push_back(make_exec(rvx_pkg::OP_ADD, 5'd11, 5'd1, 5'd2, 32'd0));
      pending_items.push_back(make_resp(32'hDEAD_BEEF));
      pending_items.push_back(make_exec(rvx_pkg::OP_LBU, 5'd12, 5'd1, 5'd0, 32'd1));
      pending_items.push_back(make_resp(32'h0000_00FF));
      pending_items.push_back(make_exec(OP_UNIMPL, 5'd13, 5'd12, 5'd0, 32'd0));
      pending_items.push_back(make_exec(OP_LAST, 5'd13, 5'd12, 5'd0, 32'd0));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_items.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rvx_pkg::rsp_type exp_r;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(execute_item(req_ch.data));
            accepted_count <= accepted_count + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("Result item with no expectation waiting: %p", rsp_ch.data);
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== rsp_ch.data) begin
                  error_count <= error_count + 1;
                  if (exp_r.next_pc !== rsp_ch.data.next_pc)
                     $error("next_pc exp %h got %h", exp_r.next_pc, rsp_ch.data.next_pc);
                  if (exp_r.mem_request !== rsp_ch.data.mem_request)
                     $error("mem_request exp %b got %b", exp_r.mem_request,
                        rsp_ch.data.mem_request);
                  if (exp_r.mem_is_write !== rsp_ch.data.mem_is_write)
                     $error("mem_is_write exp %b got %b", exp_r.mem_is_write,
                        rsp_ch.data.mem_is_write);
                  if (exp_r.mem_address !== rsp_ch.data.mem_address)
                     $error("mem_address exp %h got %h", exp_r.mem_address,
                        rsp_ch.data.mem_address);
                  if (exp_r.mem_write_data !== rsp_ch.data.mem_write_data)
                     $error("mem_write_data exp %h got %h", exp_r.mem_write_data,
                        rsp_ch.data.mem_write_data);
                  if (exp_r.mem_size !== rsp_ch.data.mem_size)
                     $error("mem_size exp %0d got %0d", exp_r.mem_size, rsp_ch.data.mem_size);
                  if (exp_r.load_is_unsigned !== rsp_ch.data.load_is_unsigned)
                     $error("load_is_unsigned exp %b got %b", exp_r.load_is_unsigned,
                        rsp_ch.data.load_is_unsigned);
                  if (exp_r.halted !== rsp_ch.data.halted)
                     $error("halted exp %b got %b", exp_r.halted, rsp_ch.data.halted);
                  if (exp_r.unimplemented_seen !== rsp_ch.data.unimplemented_seen)
                     $error("unimplemented_seen exp %b got %b", exp_r.unimplemented_seen,
                        rsp_ch.data.unimplemented_seen);
                  if (exp_r.retired_count !== rsp_ch.data.retired_count)
                     $error("retired_count exp %0d got %0d", exp_r.retired_count,
                        rsp_ch.data.retired_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic run_phase(int send_pct, int recv_pct, int n);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(n);
      wait (pending_items.size() == 0);
   endtask

   initial begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      pc_model = '0;
      count_model = '0;
      load_wait = 1'b0;
      load_dest = '0;
      halt_model = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      accepted_count = 0;
      result_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      // The halt is placed late so that most random items still execute.
      run_phase(0, 0, RANDOM_ITEMS / 4);
      run_phase(47, 0, RANDOM_ITEMS / 4);
      run_phase(0, 47, RANDOM_ITEMS / 4);
      run_phase(14, 14, RANDOM_ITEMS / 4 - 10);
      pending_items.push_back(make_exec(rvx_pkg::OP_HCF, 5'd0, 5'd0, 5'd0, 32'd0));
      queue_random(10);
      wait (pending_items.size() == 0);
      @(posedge clock);
      while (req_ch.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Run covered %0d accepted items and %0d checked results,",
         accepted_count, result_count);
      $display("with loads, stores, branches, jumps, halt and all idling phases.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
src/rvx_pkg.sv
src/rvx_if.sv
src/rvx_regfile.sv
src/rvx_alu.sv
src/rv32i_execute_core_unit.sv
dv/tb_rv32i_execute_core_unit.sv
